@@ design/i2c_master_byte_engine_defines.svh @@
// Assertion macros for the I2C master byte engine.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c master byte engine: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c master byte engine: next-cycle check failed");

`endif

@@ design/i2c_mbe_pkg.sv @@
// Shared types and constants of the I2C master byte engine.
// No dependencies.
package i2c_mbe_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int BIT_IDX_W   = 4;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;

    localparam logic [CFG_W-1:0] PHASE_DELAY_RESET = 8'd5;
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_DELAY = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic [13:0] {
        PH_IDLE     = 14'b00000000000001,
        PH_START_A  = 14'b00000000000010,
        PH_START_B  = 14'b00000000000100,
        PH_STOP_A   = 14'b00000000001000,
        PH_STOP_B   = 14'b00000000010000,
        PH_W_SETUP  = 14'b00000000100000,
        PH_W_HIGH   = 14'b00000001000000,
        PH_W_LOW    = 14'b00000010000000,
        PH_ACK_WAIT = 14'b00000100000000,
        PH_ACK_POLL = 14'b00001000000000,
        PH_R_LOW    = 14'b00010000000000,
        PH_R_HIGH   = 14'b00100000000000,
        PH_RA_LOW   = 14'b01000000000000,
        PH_RA_HIGH  = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic                 cmd_valid;
        cmd_t                 command;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_sample;
    } in_item_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 ready_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ack_failed;
    } result_t;

endpackage

@@ design/i2c_mbe_in_stage.sv @@
// Input register of the I2C master byte engine: unpacks and holds one tick.
// Depends on i2c_mbe_pkg.
module i2c_mbe_in_stage
    import i2c_mbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // tx_byte[7:0], send_ack, sda_sample, zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // cmd_valid, command[1:0]
    input  logic                 advance,
    output logic                 item_valid,
    output in_item_t             item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     s_accept;

    assign s_tready   = !valid_reg || advance;
    assign s_accept   = s_tvalid && s_tready;
    assign valid_next = s_accept || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.cmd_valid  <= s_tuser[0];
            item_reg.command    <= cmd_t'(s_tuser[2:1]);
            item_reg.tx_byte    <= s_tdata[BYTE_BITS-1:0];
            item_reg.send_ack   <= s_tdata[BYTE_BITS];
            item_reg.sda_sample <= s_tdata[BYTE_BITS+1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/i2c_mbe_core.sv @@
// Bus phase sequencer of the I2C master byte engine: state, config registers
// and the one-tick next-state logic. Depends on i2c_mbe_pkg.
module i2c_mbe_core
    import i2c_mbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 step,
    input  in_item_t             item,
    output result_t              res
);

    logic [CFG_W-1:0]     phase_delay_reg;
    logic [CFG_W-1:0]     ack_timeout_reg;

    phase_t               phase_reg,  phase_next;
    logic [BIT_IDX_W-1:0] bit_reg,    bit_next;
    logic [BYTE_BITS-1:0] shift_reg,  shift_next;
    logic [7:0]           delay_reg,  delay_next;
    logic [7:0]           poll_reg,   poll_next;
    logic                 scl_reg,    scl_next;
    logic                 sda_reg,    sda_next;
    logic                 fail_reg,   fail_next;
    logic                 ack_reg,    ack_next;
    logic [BYTE_BITS-1:0] rx_reg,     rx_next;
    logic                 done;

    logic [7:0]           limit;
    logic [7:0]           delay_inc;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [BYTE_BITS-1:0] shift_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_delay_reg <= PHASE_DELAY_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_PHASE_DELAY: phase_delay_reg <= cfg_wdata;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign limit     = (phase_delay_reg == '0) ? 8'd1 : phase_delay_reg;
    assign delay_inc = delay_reg + 8'd1;
    assign bit_inc   = bit_reg + 1'b1;
    assign shift_up  = {shift_reg[BYTE_BITS-2:0], 1'b0};

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        fail_next  = fail_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (item.cmd_valid) begin
                delay_next = '0;
                case (item.command)
                    CMD_START: begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PH_START_A;
                    end
                    CMD_STOP: begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_A;
                    end
                    CMD_WRITE: begin
                        fail_next  = 1'b0;
                        shift_next = item.tx_byte;
                        bit_next   = '0;
                        scl_next   = 1'b0;
                        sda_next   = item.tx_byte[BYTE_BITS-1];
                        phase_next = PH_W_SETUP;
                    end
                    default: begin
                        ack_next   = item.send_ack;
                        shift_next = '0;
                        bit_next   = '0;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_R_LOW;
                    end
                endcase
            end
        end else if (phase_reg == PH_ACK_POLL) begin
            if (!item.sda_sample) begin
                scl_next   = 1'b0;
                fail_next  = 1'b0;
                delay_next = '0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end else if (poll_reg >= ack_timeout_reg) begin
                fail_next  = 1'b1;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                delay_next = '0;
                phase_next = PH_STOP_A;
            end else begin
                poll_next = poll_reg + 8'd1;
            end
        end else begin
            delay_next = delay_inc;
            if (delay_inc >= limit) begin
                delay_next = '0;
                case (phase_reg)
                    PH_START_A: begin
                        sda_next   = 1'b0;
                        phase_next = PH_START_B;
                    end
                    PH_START_B: begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_STOP_A: begin
                        scl_next   = 1'b1;
                        phase_next = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_W_SETUP: begin
                        scl_next   = 1'b1;
                        phase_next = PH_W_HIGH;
                    end
                    PH_W_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_W_LOW;
                    end
                    PH_W_LOW: begin
                        bit_next = bit_inc;
                        if (bit_inc < BIT_IDX_W'(BYTE_BITS)) begin
                            shift_next = shift_up;
                            sda_next   = shift_up[BYTE_BITS-1];
                            phase_next = PH_W_SETUP;
                        end else begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            poll_next  = '0;
                            phase_next = PH_ACK_WAIT;
                        end
                    end
                    PH_ACK_WAIT: begin
                        poll_next  = '0;
                        phase_next = PH_ACK_POLL;
                    end
                    PH_R_LOW: begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[BYTE_BITS-2:0], item.sda_sample};
                        phase_next = PH_R_HIGH;
                    end
                    PH_R_HIGH: begin
                        bit_next = bit_inc;
                        scl_next = 1'b0;
                        if (bit_inc < BIT_IDX_W'(BYTE_BITS)) begin
                            phase_next = PH_R_LOW;
                        end else begin
                            rx_next    = shift_reg;
                            sda_next   = !ack_reg;
                            phase_next = PH_RA_LOW;
                        end
                    end
                    PH_RA_LOW: begin
                        scl_next   = 1'b1;
                        phase_next = PH_RA_HIGH;
                    end
                    PH_RA_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            delay_reg <= '0;
            poll_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            fail_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            rx_reg    <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            fail_reg  <= fail_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    assign res.scl_level  = scl_next;
    assign res.sda_level  = sda_next;
    assign res.ready_res  = (phase_next == PH_IDLE);
    assign res.done_res   = done;
    assign res.rx_byte    = rx_next;
    assign res.ack_failed = fail_next;

endmodule

@@ design/i2c_mbe_out_stage.sv @@
// Result register of the I2C master byte engine: holds and packs one result.
// Depends on i2c_mbe_pkg.
module i2c_mbe_out_stage
    import i2c_mbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              res,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata  // scl, sda, ready, done, rx_byte[7:0], ack_failed, pad
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, res_reg.ack_failed, res_reg.rx_byte, res_reg.done_res,
                       res_reg.ready_res, res_reg.sda_level, res_reg.scl_level};

endmodule

@@ design/i2c_master_byte_engine.sv @@
// I2C master byte engine, top level. One transaction in gives one result out.
// Path from input accept to result valid: input register, then result register.
// Throughput: one transaction per cycle unless a full result register stalls the input (m_tready low).
// Reset: aresetn synchronous active low; idle phase, SCL and SDA released,
// phase delay 5 and ACK timeout 250 ticks, received byte and fail flag cleared.
`include "i2c_master_byte_engine_defines.svh"
module i2c_master_byte_engine
    import i2c_mbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // tx_byte[7:0], send_ack, sda_sample, zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // cmd_valid, command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // scl, sda, ready, done, rx_byte[7:0], ack_failed, pad
);

    logic     item_valid;
    in_item_t item;
    logic     space;
    logic     advance;
    result_t  res;

    assign advance = item_valid && space;

    i2c_mbe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2c_mbe_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (item),
        .res       (res)
    );

    i2c_mbe_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `MBE_ASSERT_SAME(a_done_implies_ready, aclk, aresetn, res.done_res, res.ready_res)
    `MBE_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, m_tvalid)
    `MBE_ASSERT_NEXT(a_stalled_item_held, aclk, aresetn, item_valid && !space, item_valid)

endmodule
